// File: rtl/csvp_pkg.sv
// Shared types, codes and default sizes for the CSV column profiler.
package csvp_pkg;

    localparam int DEF_MAX_FIELDS  = 64;
    localparam int DEF_LEN_BITS    = 16;
    localparam int DEF_COUNT_BITS  = 32;

    localparam int BYTE_W          = 8;
    localparam int CFG_INDEX_W     = 2;
    localparam int FIELD_INDEX_W   = 6;
    localparam int COL_WIDTH_W     = 16;
    localparam int COUNT_OUT_W     = 32;
    localparam int LINE_LEN_OUT_W  = 16;
    localparam int OUT_DATA_W      = 112;

    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUOTE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER    = 2'd2;

    localparam logic [BYTE_W-1:0] SEP_RESET   = 8'd59;
    localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

    typedef enum logic [2:0] {
        VT_NONE,
        VT_NULL,
        VT_BOOL,
        VT_INT,
        VT_FLOAT,
        VT_STRING
    } vtype_t;

    typedef enum logic [3:0] {
        CS_EMPTY,
        CS_STR,
        CS_SIGN,
        CS_ZERO,
        CS_ONE,
        CS_INTD,
        CS_FDIG,
        CS_FDOT,
        CS_FFRAC,
        CS_FEXP,
        CS_FESIGN,
        CS_FEXPD
    } class_state_t;

    typedef struct packed {
        logic   upd;
        logic   hdr;
        vtype_t vt;
    } col_ctrl_t;

endpackage

// File: rtl/csvp_classify.sv
// Field classifier: one step of the number/bool recognizer and the final type of a field.
module csvp_classify (
    input  csvp_pkg::class_state_t class_state,
    input  logic [7:0]             text_byte,
    input  logic [7:0]             quote_char,
    output csvp_pkg::class_state_t class_next,
    output csvp_pkg::vtype_t       final_type
);
    import csvp_pkg::*;

    logic is_dig;
    logic is_exp;
    logic is_sign;
    logic is_dot;

    assign is_dig  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_exp  = (text_byte == 8'h65) || (text_byte == 8'h45);
    assign is_sign = (text_byte == 8'h2B) || (text_byte == 8'h2D);
    assign is_dot  = (text_byte == 8'h2E);

    always_comb begin
        case (class_state)
            CS_EMPTY: begin
                if (quote_char != 8'h00 && text_byte == quote_char) class_next = CS_STR;
                else if (text_byte == 8'h30) class_next = CS_ZERO;
                else if (text_byte == 8'h31) class_next = CS_ONE;
                else if (is_dig)             class_next = CS_INTD;
                else if (is_sign)            class_next = CS_SIGN;
                else                         class_next = CS_STR;
            end
            CS_SIGN: begin
                if (text_byte == 8'h30) class_next = CS_FDIG;
                else if (is_dig)        class_next = CS_INTD;
                else if (is_dot)        class_next = CS_FDOT;
                else                    class_next = CS_STR;
            end
            CS_ZERO, CS_FDIG: begin
                if (is_dig)      class_next = CS_FDIG;
                else if (is_dot) class_next = CS_FDOT;
                else if (is_exp) class_next = CS_FEXP;
                else             class_next = CS_STR;
            end
            CS_ONE, CS_INTD: begin
                if (is_dig)      class_next = CS_INTD;
                else if (is_dot) class_next = CS_FDOT;
                else if (is_exp) class_next = CS_FEXP;
                else             class_next = CS_STR;
            end
            CS_FDOT: begin
                if (is_dig) class_next = CS_FFRAC;
                else        class_next = CS_STR;
            end
            CS_FFRAC: begin
                if (is_dig)      class_next = CS_FFRAC;
                else if (is_exp) class_next = CS_FEXP;
                else             class_next = CS_STR;
            end
            CS_FEXP: begin
                if (is_sign)     class_next = CS_FESIGN;
                else if (is_dig) class_next = CS_FEXPD;
                else             class_next = CS_STR;
            end
            CS_FESIGN, CS_FEXPD: begin
                if (is_dig) class_next = CS_FEXPD;
                else        class_next = CS_STR;
            end
            default: class_next = CS_STR;
        endcase
    end

    always_comb begin
        case (class_state)
            CS_EMPTY:                    final_type = VT_NULL;
            CS_ZERO, CS_ONE:             final_type = VT_BOOL;
            CS_INTD:                     final_type = VT_INT;
            CS_FDIG, CS_FFRAC, CS_FEXPD: final_type = VT_FLOAT;
            default:                     final_type = VT_STRING;
        endcase
    end

endmodule

// File: rtl/csvp_col_table.sv
// Per-column statistics memory with read-modify-write, write bypass and clearing pass.
module csvp_col_table #(
    parameter int MAX_FIELDS = csvp_pkg::DEF_MAX_FIELDS,
    parameter int LEN_BITS   = csvp_pkg::DEF_LEN_BITS,
    parameter int COUNT_BITS = csvp_pkg::DEF_COUNT_BITS,
    parameter int IDX_BITS   = $clog2(MAX_FIELDS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [IDX_BITS-1:0]       rd_addr,
    input  logic [IDX_BITS-1:0]       wr_addr,
    input  csvp_pkg::col_ctrl_t       ctrl,
    input  logic [LEN_BITS-1:0]       field_len,
    output logic                      busy,
    output csvp_pkg::vtype_t          col_type,
    output logic [LEN_BITS-1:0]       col_width,
    output logic [COUNT_BITS-1:0]     col_nulls
);
    import csvp_pkg::*;

    vtype_t                type_mem  [MAX_FIELDS];
    logic [LEN_BITS-1:0]   width_mem [MAX_FIELDS];
    logic [COUNT_BITS-1:0] null_mem  [MAX_FIELDS];

    vtype_t                rd_type_reg;
    logic [LEN_BITS-1:0]   rd_width_reg;
    logic [COUNT_BITS-1:0] rd_null_reg;

    logic                  clr_busy_reg;
    logic [IDX_BITS-1:0]   clr_addr_reg;

    logic                  we;
    logic [IDX_BITS-1:0]   waddr;
    vtype_t                wtype;
    logic [LEN_BITS-1:0]   wwidth;
    logic [COUNT_BITS-1:0] wnull;

    // updated entry for the column being closed
    always_comb begin
        col_type  = rd_type_reg;
        col_width = rd_width_reg;
        col_nulls = rd_null_reg;
        if (field_len > rd_width_reg) col_width = field_len;
        if (!ctrl.hdr) begin
            if (ctrl.vt > rd_type_reg) col_type = ctrl.vt;
            if (ctrl.vt == VT_NULL && rd_null_reg != '1)
                col_nulls = rd_null_reg + COUNT_BITS'(1);
        end
    end

    always_comb begin
        if (clr_busy_reg) begin
            we     = 1'b1;
            waddr  = clr_addr_reg;
            wtype  = VT_NONE;
            wwidth = '0;
            wnull  = '0;
        end else begin
            we     = ctrl.upd;
            waddr  = wr_addr;
            wtype  = col_type;
            wwidth = col_width;
            wnull  = col_nulls;
        end
    end

    assign busy = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + IDX_BITS'(1);
            if (clr_addr_reg == IDX_BITS'(MAX_FIELDS - 1)) clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            type_mem[waddr]  <= wtype;
            width_mem[waddr] <= wwidth;
            null_mem[waddr]  <= wnull;
        end
    end

    always_ff @(posedge aclk) begin
        if (we && waddr == rd_addr) begin
            rd_type_reg  <= wtype;
            rd_width_reg <= wwidth;
            rd_null_reg  <= wnull;
        end else begin
            rd_type_reg  <= type_mem[rd_addr];
            rd_width_reg <= width_mem[rd_addr];
            rd_null_reg  <= null_mem[rd_addr];
        end
    end

endmodule

// File: rtl/csv_column_profiler.sv
// Top level of the CSV column profiler: byte parser, line statistics and result register.
// A result appears in the output register in the cycle after the transfer of the
// byte that ends its field. Throughput: one byte per cycle; the column table
// read-modify-write for an ended field fits in that cycle, and a result held by m_tready
// low stalls the input until it is taken.
// After the synchronous reset (aresetn low) the column table is cleared, all MAX_FIELDS
// entries, during which no byte is taken; configuration writes are taken at any time.
module csv_column_profiler #(
    parameter int MAX_FIELDS = csvp_pkg::DEF_MAX_FIELDS,
    parameter int LEN_BITS   = csvp_pkg::DEF_LEN_BITS,
    parameter int COUNT_BITS = csvp_pkg::DEF_COUNT_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // text_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // field_index, value_type, column_type, column_width, column_nulls, line_count,
    // longest_line, count_mismatch, crlf_seen, field_overflow, zero pad
    output logic [csvp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,   // header_field
    output logic                                 m_tlast    // line_end
);
    import csvp_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_FIELDS);
    localparam int FC_BITS  = $clog2(MAX_FIELDS + 1);
    localparam int IW  = (FC_BITS > FIELD_INDEX_W) ? FC_BITS : FIELD_INDEX_W;
    localparam int LW  = (LEN_BITS > COL_WIDTH_W) ? LEN_BITS : COL_WIDTH_W;
    localparam int CW  = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

    logic [7:0]            sep_reg;
    logic [7:0]            quote_reg;
    logic                  hdr_cfg_reg;

    logic                  in_quotes_reg,  in_quotes_next;
    logic [FC_BITS-1:0]    cur_field_reg,  cur_field_next;
    logic [LEN_BITS-1:0]   field_len_reg,  field_len_next;
    logic [LEN_BITS-1:0]   line_len_reg,   line_len_next;
    class_state_t          class_reg,      class_next;
    logic [COUNT_BITS-1:0] lines_done_reg, lines_done_next;
    logic [FC_BITS-1:0]    first_fields_reg, first_fields_next;
    logic [LEN_BITS-1:0]   max_line_reg,   max_line_next;
    logic                  after_lf_reg,   after_lf_next;
    logic                  crlf_reg,       crlf_next;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg,     m_data_next;
    logic                  m_user_reg,     m_user_next;
    logic                  m_last_reg,     m_last_next;

    logic                  s_fire;
    logic                  skip_cr;
    logic                  is_quote;
    logic                  lend;
    logic                  is_sep;
    logic                  field_end;
    logic                  produce;
    logic                  ovf;
    logic                  hdr;
    logic                  mism;
    logic [LEN_BITS-1:0]   line_len_inc;
    logic [FC_BITS-1:0]    cur_field_inc;

    class_state_t          cls_step;
    vtype_t                cls_type;
    vtype_t                vt;

    col_ctrl_t             tbl_ctrl;
    logic                  tbl_busy;
    logic [IDX_BITS-1:0]   tbl_rd_addr;
    logic [IDX_BITS-1:0]   tbl_wr_addr;
    vtype_t                tbl_type;
    logic [LEN_BITS-1:0]   tbl_width;
    logic [COUNT_BITS-1:0] tbl_nulls;

    logic [IW-1:0]         idx_ext;
    logic [LW-1:0]         cw_ext;
    logic [LW-1:0]         ll_ext;
    logic [CW-1:0]         cn_ext;
    logic [CW-1:0]         lc_ext;
    vtype_t                ct_out;
    logic [COL_WIDTH_W-1:0]    cw_out;
    logic [COUNT_OUT_W-1:0]    cn_out;
    logic [COUNT_OUT_W-1:0]    lc_out;
    logic [LINE_LEN_OUT_W-1:0] ll_out;

    function automatic logic [IDX_BITS-1:0] col_addr(input logic [FC_BITS-1:0] cf);
        if (cf >= FC_BITS'(MAX_FIELDS)) col_addr = '0;
        else                            col_addr = cf[IDX_BITS-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !tbl_busy && (!m_valid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    csvp_classify u_class (
        .class_state (class_reg),
        .text_byte   (s_tdata),
        .quote_char  (quote_reg),
        .class_next  (cls_step),
        .final_type  (cls_type)
    );

    // byte decode
    always_comb begin
        skip_cr        = after_lf_reg && (s_tdata == BYTE_CR);
        is_quote       = (quote_reg != 8'h00) && (s_tdata == quote_reg);
        in_quotes_next = in_quotes_reg ^ is_quote;
        lend           = (s_tdata == BYTE_LF);
        is_sep         = (sep_reg != 8'h00) && (s_tdata == sep_reg);
        field_end      = !in_quotes_next && (lend || is_sep);
        produce        = s_fire && !skip_cr && field_end;
        line_len_inc   = (line_len_reg == '1) ? line_len_reg : line_len_reg + LEN_BITS'(1);
        cur_field_inc  = (cur_field_reg < FC_BITS'(MAX_FIELDS)) ?
                         cur_field_reg + FC_BITS'(1) : cur_field_reg;
        ovf = (cur_field_reg >= FC_BITS'(MAX_FIELDS)) ||
              ((lines_done_reg != '0) && (cur_field_reg >= first_fields_reg));
        hdr = hdr_cfg_reg && (lines_done_reg == '0);
        vt  = hdr ? VT_NONE : cls_type;
    end

    // parser state update
    always_comb begin
        cur_field_next    = cur_field_reg;
        field_len_next    = field_len_reg;
        line_len_next     = line_len_reg;
        class_next        = class_reg;
        lines_done_next   = lines_done_reg;
        first_fields_next = first_fields_reg;
        max_line_next     = max_line_reg;
        after_lf_next     = after_lf_reg;
        crlf_next         = crlf_reg;
        mism              = 1'b0;
        if (s_fire) begin
            after_lf_next = 1'b0;
            if (skip_cr) begin
                crlf_next = 1'b1;
            end else if (!field_end) begin
                line_len_next  = line_len_inc;
                field_len_next = (field_len_reg == '1) ?
                                 field_len_reg : field_len_reg + LEN_BITS'(1);
                class_next     = cls_step;
            end else begin
                line_len_next  = line_len_inc;
                cur_field_next = cur_field_inc;
                field_len_next = '0;
                class_next     = CS_EMPTY;
                if (lend) begin
                    if (lines_done_reg == '0) first_fields_next = cur_field_inc;
                    else mism = (cur_field_inc != first_fields_reg);
                    if (lines_done_reg != '1) lines_done_next = lines_done_reg + COUNT_BITS'(1);
                    if (line_len_inc > max_line_reg) max_line_next = line_len_inc;
                    line_len_next  = '0;
                    cur_field_next = '0;
                    after_lf_next  = 1'b1;
                end
            end
        end
    end

    assign tbl_ctrl.upd = produce && !ovf;
    assign tbl_ctrl.hdr = hdr;
    assign tbl_ctrl.vt  = vt;
    assign tbl_rd_addr  = col_addr(cur_field_next);
    assign tbl_wr_addr  = col_addr(cur_field_reg);

    csvp_col_table #(
        .MAX_FIELDS (MAX_FIELDS),
        .LEN_BITS   (LEN_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_col_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr   (tbl_rd_addr),
        .wr_addr   (tbl_wr_addr),
        .ctrl      (tbl_ctrl),
        .field_len (field_len_reg),
        .busy      (tbl_busy),
        .col_type  (tbl_type),
        .col_width (tbl_width),
        .col_nulls (tbl_nulls)
    );

    // result assembly, counters capped at the result field widths
    always_comb begin
        idx_ext = IW'(cur_field_reg);
        cw_ext  = ovf ? '0 : LW'(tbl_width);
        cn_ext  = ovf ? '0 : CW'(tbl_nulls);
        ct_out  = ovf ? VT_NONE : tbl_type;
        lc_ext  = CW'(lines_done_next);
        ll_ext  = LW'(max_line_next);
        cw_out  = (cw_ext > LW'({COL_WIDTH_W{1'b1}})) ? '1 : cw_ext[COL_WIDTH_W-1:0];
        cn_out  = (cn_ext > CW'({COUNT_OUT_W{1'b1}})) ? '1 : cn_ext[COUNT_OUT_W-1:0];
        lc_out  = (lc_ext > CW'({COUNT_OUT_W{1'b1}})) ? '1 : lc_ext[COUNT_OUT_W-1:0];
        ll_out  = (ll_ext > LW'({LINE_LEN_OUT_W{1'b1}})) ? '1 : ll_ext[LINE_LEN_OUT_W-1:0];
        m_data_next = {1'b0, ovf, crlf_reg, mism, ll_out, lc_out, cn_out, cw_out,
                       ct_out, vt, idx_ext[FIELD_INDEX_W-1:0]};
        m_user_next = hdr;
        m_last_next = lend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg     <= SEP_RESET;
            quote_reg   <= QUOTE_RESET;
            hdr_cfg_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SEPARATOR: sep_reg     <= cfg_data;
                REG_QUOTE:     quote_reg   <= cfg_data;
                REG_HEADER:    hdr_cfg_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg    <= 1'b0;
            cur_field_reg    <= '0;
            field_len_reg    <= '0;
            line_len_reg     <= '0;
            class_reg        <= CS_EMPTY;
            lines_done_reg   <= '0;
            first_fields_reg <= '0;
            max_line_reg     <= '0;
            after_lf_reg     <= 1'b0;
            crlf_reg         <= 1'b0;
        end else begin
            if (s_fire && !skip_cr) in_quotes_reg <= in_quotes_next;
            cur_field_reg    <= cur_field_next;
            field_len_reg    <= field_len_next;
            line_len_reg     <= line_len_next;
            class_reg        <= class_next;
            lines_done_reg   <= lines_done_next;
            first_fields_reg <= first_fields_next;
            max_line_reg     <= max_line_next;
            after_lf_reg     <= after_lf_next;
            crlf_reg         <= crlf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= m_last_next;
        end
    end

    a_lf_gives_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && lend) |=> (m_tvalid && m_tlast && cur_field_reg == '0 && after_lf_reg))
        else $error("line end transfer did not close the line");

    a_first_count_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (lines_done_reg != '0) |-> (first_fields_reg != '0))
        else $error("first line field count missing after a completed line");

    a_field_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_field_reg <= FC_BITS'(MAX_FIELDS))
        else $error("field counter past its limit");

    a_no_take_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_busy |-> !s_fire && !tbl_ctrl.upd)
        else $error("byte taken while column table clears");

    a_line_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (max_line_reg != '0))
        else $error("line ended without a longest line");

endmodule
